[hdl/jfd_pkg.sv]
package jfd_pkg;

   localparam int LENGTH_BITS = 27;

   localparam logic [LENGTH_BITS-1:0] LIMIT_RESET = LENGTH_BITS'(32'd33554432);

   localparam logic [7:0] MARK_LEAD = 8'hFF;
   localparam logic [7:0] MARK_SOI  = 8'hD8;
   localparam logic [7:0] MARK_EOI  = 8'hD9;

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-3:0] REG_MAX_FRAME_BYTES = '0;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_LAST  = 2'd2;
   localparam logic [1:0] KIND_ABORT = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } jfd_entry_type;

endpackage

[hdl/jfd_front.sv]
module jfd_front
   import jfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [7:0]             req_data_byte,
   output logic                   req_stall,
   input  logic [LENGTH_BITS-1:0] max_frame_bytes,
   input  logic                   queue_full,
   output logic                   push,
   output jfd_entry_type          push_entry
);

   logic                   inside_ff;
   logic                   inside_in;
   logic                   prev_lead_ff;
   logic                   prev_lead_in;
   logic [LENGTH_BITS-1:0] length_ff;
   logic [LENGTH_BITS-1:0] length_in;
   logic [LENGTH_BITS:0]   next_len;
   logic                   accept;
   logic                   over;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign next_len  = {1'b0, length_ff} + {{LENGTH_BITS{1'b0}}, 1'b1};
   assign over      = next_len > {1'b0, max_frame_bytes};

   always_comb begin
      inside_in       = inside_ff;
      prev_lead_in    = prev_lead_ff;
      length_in       = length_ff;
      push            = 1'b0;
      push_entry.kind = KIND_DATA;
      push_entry.data = req_data_byte;
      if (accept) begin
         if (!inside_ff) begin
            if (prev_lead_ff && req_data_byte == MARK_SOI) begin
               push            = 1'b1;
               push_entry.kind = KIND_START;
               inside_in       = 1'b1;
               prev_lead_in    = 1'b0;
               length_in       = LENGTH_BITS'(2);
            end else begin
               prev_lead_in = (req_data_byte == MARK_LEAD);
            end
         end else if (over) begin
            push            = 1'b1;
            push_entry.kind = KIND_ABORT;
            inside_in       = 1'b0;
            prev_lead_in    = 1'b0;
            length_in       = '0;
         end else if (prev_lead_ff && req_data_byte == MARK_EOI) begin
            push            = 1'b1;
            push_entry.kind = KIND_LAST;
            inside_in       = 1'b0;
            prev_lead_in    = 1'b0;
            length_in       = '0;
         end else begin
            push         = 1'b1;
            length_in    = next_len[LENGTH_BITS-1:0];
            prev_lead_in = (req_data_byte == MARK_LEAD);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff    <= 1'b0;
         prev_lead_ff <= 1'b0;
         length_ff    <= '0;
      end else begin
         inside_ff    <= inside_in;
         prev_lead_ff <= prev_lead_in;
         length_ff    <= length_in;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset) !inside_ff |-> length_ff == '0)
      else $error("frame length is nonzero while hunting");
   assert property (@(posedge clock) disable iff (reset)
      push && push_entry.kind == KIND_START |=> inside_ff && length_ff == LENGTH_BITS'(2))
      else $error("start marker did not open a frame of length two");
`endif

endmodule

[hdl/jfd_queue.sv]
module jfd_queue
   import jfd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  jfd_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          empty,
   output jfd_entry_type pop_entry
);

   jfd_entry_type             entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff;
   logic [QUEUE_CNT_BITS-1:0] count_in;

   assign full      = count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign pop_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue written while full");
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue read while empty");
`endif

endmodule

[hdl/jfd_back.sv]
module jfd_back
   import jfd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          queue_empty,
   input  jfd_entry_type queue_entry,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_frame_byte,
   output logic          rsp_frame_first,
   output logic          rsp_frame_last,
   output logic          rsp_frame_abort
);

   logic       valid_ff;
   logic       valid_in;
   logic       soi_pend_ff;
   logic       soi_pend_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       first_ff;
   logic       first_in;
   logic       last_ff;
   logic       last_in;
   logic       abort_ff;
   logic       abort_in;
   logic       load;

   assign load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in    = valid_ff;
      soi_pend_in = soi_pend_ff;
      byte_in     = byte_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      abort_in    = abort_ff;
      pop         = 1'b0;
      if (load) begin
         first_in = 1'b0;
         last_in  = 1'b0;
         abort_in = 1'b0;
         byte_in  = queue_entry.data;
         if (soi_pend_ff) begin
            valid_in    = 1'b1;
            soi_pend_in = 1'b0;
            byte_in     = MARK_SOI;
         end else if (!queue_empty) begin
            pop      = 1'b1;
            valid_in = 1'b1;
            case (queue_entry.kind)
               KIND_START: begin
                  byte_in     = MARK_LEAD;
                  first_in    = 1'b1;
                  soi_pend_in = 1'b1;
               end
               KIND_LAST: begin
                  last_in = 1'b1;
               end
               KIND_ABORT: begin
                  abort_in = 1'b1;
               end
               default: begin
               end
            endcase
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         soi_pend_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         soi_pend_ff <= soi_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      abort_ff <= abort_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_frame_byte  = byte_ff;
   assign rsp_frame_first = first_ff;
   assign rsp_frame_last  = last_ff;
   assign rsp_frame_abort = abort_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      soi_pend_ff |-> valid_ff && first_ff && byte_ff == MARK_LEAD)
      else $error("start marker second byte pending without its lead byte shown");
`endif

endmodule

[hdl/jpeg_frame_deframer_core.sv]
// Cuts JPEG frames out of a byte stream: while hunting it waits for FF D8, then passes every
// byte of the frame with the opening FF flagged first and the closing D9 flagged last; a byte
// that would make the frame longer than max_frame_bytes comes out with the abort flag and the
// block hunts again. One byte is taken per clock while the queue is not full; bytes pass the
// queue to the result register. The start marker gives two results from its second byte, which
// a four-entry queue between the classifier and the output stage absorbs; the output register
// gives one result per clock unless stalled. The size limit sits at byte address 0 of the register port.
module jpeg_frame_deframer_core
   import jfd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_data_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_frame_byte,
   output logic                     rsp_frame_first,
   output logic                     rsp_frame_last,
   output logic                     rsp_frame_abort,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   logic [LENGTH_BITS-1:0] max_frame_bytes_ff;
   logic [LENGTH_BITS-1:0] max_frame_bytes_in;
   logic                   max_hit;
   logic                   push;
   logic                   pop;
   logic                   queue_full;
   logic                   queue_empty;
   jfd_entry_type          push_entry;
   jfd_entry_type          pop_entry;

   assign pready  = 1'b1;
   assign max_hit = paddr[CSR_ADDR_BITS-1:2] == REG_MAX_FRAME_BYTES;
   assign prdata  = max_hit ? CSR_DATA_BITS'(max_frame_bytes_ff) : '0;

   always_comb begin
      max_frame_bytes_in = max_frame_bytes_ff;
      if (psel && penable && pwrite && max_hit) begin
         max_frame_bytes_in = pwdata[LENGTH_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_bytes_ff <= LIMIT_RESET;
      end else begin
         max_frame_bytes_ff <= max_frame_bytes_in;
      end
   end

   jfd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_data_byte   (req_data_byte),
      .req_stall       (req_stall),
      .max_frame_bytes (max_frame_bytes_ff),
      .queue_full      (queue_full),
      .push            (push),
      .push_entry      (push_entry)
   );

   jfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .pop_entry  (pop_entry)
   );

   jfd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .queue_entry     (pop_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_frame_first (rsp_frame_first),
      .rsp_frame_last  (rsp_frame_last),
      .rsp_frame_abort (rsp_frame_abort)
   );

endmodule

[verif/tb_jpeg_frame_deframer_core.sv]
module tb_jpeg_frame_deframer_core;
   import jfd_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] LIMIT_ADDR    = {REG_MAX_FRAME_BYTES, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] UNMAPPED_ADDR = CSR_ADDR_BITS'(4);
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [7:0] value;
      logic       opens;
      logic       closes;
      logic       dropped;
   } frame_beat_type;

   class frame_cut_scoreboard;
      logic [LENGTH_BITS-1:0] limit;
      logic [LENGTH_BITS-1:0] length;
      bit                     in_frame;
      bit                     saw_lead;
      frame_beat_type         pending[$];
      int                     failures;
      int                     checked;
      int                     closed_frames;
      int                     dropped_frames;

      function new();
         limit = LIMIT_RESET;
         length = '0;
         in_frame = 0;
         saw_lead = 0;
         failures = 0;
         checked = 0;
         closed_frames = 0;
         dropped_frames = 0;
      endfunction

      function void flag(string what);
         failures++;
         if (failures <= 10) begin
            $display("Mismatch: %s", what);
         end
      endfunction

      function void expect_beat(logic [7:0] value, logic opens, logic closes, logic dropped);
         frame_beat_type beat;
         beat = '{value, opens, closes, dropped};
         pending = {pending, beat};
      endfunction

      function void take_byte(logic [7:0] b);
         logic [LENGTH_BITS:0] grown;
         if (!in_frame) begin
            if (saw_lead && b == MARK_SOI) begin
               expect_beat(MARK_LEAD, 1'b1, 1'b0, 1'b0);
               expect_beat(MARK_SOI, 1'b0, 1'b0, 1'b0);
               in_frame = 1;
               saw_lead = 0;
               length = LENGTH_BITS'(2);
            end else begin
               saw_lead = (b == MARK_LEAD);
            end
            return;
         end
         grown = {1'b0, length} + 1'b1;
         if (grown > {1'b0, limit}) begin
            expect_beat(b, 1'b0, 1'b0, 1'b1);
            in_frame = 0;
            saw_lead = 0;
            length = '0;
         end else if (saw_lead && b == MARK_EOI) begin
            expect_beat(b, 1'b0, 1'b1, 1'b0);
            in_frame = 0;
            saw_lead = 0;
            length = '0;
         end else begin
            expect_beat(b, 1'b0, 1'b0, 1'b0);
            length = grown[LENGTH_BITS-1:0];
            saw_lead = (b == MARK_LEAD);
         end
      endfunction

      function void match_result(frame_beat_type seen);
         frame_beat_type want;
         if (pending.size() == 0) begin
            flag($sformatf("unexpected result byte %02h first %b last %b abort %b",
                           seen.value, seen.opens, seen.closes, seen.dropped));
            return;
         end
         want = pending.pop_front();
         checked++;
         if (want.closes) closed_frames++;
         if (want.dropped) dropped_frames++;
         if (seen !== want) begin
            flag($sformatf({"result %0d: expected byte %02h first %b last %b abort %b, ",
                            "got byte %02h first %b last %b abort %b"}, checked,
                           want.value, want.opens, want.closes, want.dropped,
                           seen.value, seen.opens, seen.closes, seen.dropped));
         end
      endfunction

      function void check_limit(logic [CSR_DATA_BITS-1:0] got);
         if (got !== CSR_DATA_BITS'(limit)) begin
            flag($sformatf("size limit read back %0d, expected %0d", got, limit));
         end
      endfunction

      function int outstanding();
         return pending.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [7:0]               req_data_byte;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [7:0]               rsp_frame_byte;
   logic                     rsp_frame_first;
   logic                     rsp_frame_last;
   logic                     rsp_frame_abort;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   frame_cut_scoreboard tracker = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_request = 0;
   int bytes_sent = 0;
   int limit_settings = 0;

   jpeg_frame_deframer_core DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_frame_first(rsp_frame_first),
      .rsp_frame_last(rsp_frame_last),
      .rsp_frame_abort(rsp_frame_abort),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int hold_left;
      frame_beat_type seen;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            seen = '{rsp_frame_byte, rsp_frame_first, rsp_frame_last, rsp_frame_abort};
            tracker.match_result(seen);
         end
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
         end
      end
   end

   function automatic logic [7:0] stream_byte();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) return MARK_LEAD;
      if (pick < 20) return MARK_SOI;
      if (pick < 25) return MARK_EOI;
      return 8'($urandom);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.take_byte(b);
      bytes_sent++;
   endtask

   task automatic send_frame(input int body_len, input bit closed);
      int i;
      send_byte(MARK_LEAD);
      send_byte(MARK_SOI);
      for (i = 0; i < body_len; i++) send_byte(stream_byte());
      if (closed) begin
         send_byte(MARK_LEAD);
         send_byte(MARK_EOI);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (addr == LIMIT_ADDR) tracker.limit = value[LENGTH_BITS-1:0];
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_limit_reg();
      logic [CSR_DATA_BITS-1:0] value;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= LIMIT_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      value = prdata;
      tracker.check_limit(value);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_limit(input logic [CSR_DATA_BITS-1:0] value);
      csr_write(LIMIT_ADDR, value);
      check_limit_reg();
      limit_settings++;
   endtask

   task automatic random_traffic(input int quota);
      int start_count;
      int pick;
      int body;
      start_count = bytes_sent;
      while (bytes_sent - start_count < quota) begin
         pick = $urandom_range(99);
         body = ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(20, 0);
         if (pick < 80) begin
            send_frame(body, 1'b1);
         end else if (pick < 90) begin
            repeat ($urandom_range(6, 1)) send_byte(stream_byte());
         end else begin
            send_frame(body, 1'b0);
         end
      end
   endtask

   initial begin
      logic [CSR_DATA_BITS-1:0] limits[8];
      int phase;
      int mode;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= 8'h00;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_limit_reg();

      send_byte(8'h00);
      send_byte(MARK_LEAD);
      send_byte(MARK_LEAD);
      send_byte(MARK_SOI);
      send_byte(8'h00);
      send_byte(MARK_LEAD);
      send_byte(MARK_SOI);
      send_byte(8'h7F);
      send_byte(8'h80);
      send_byte(MARK_LEAD);
      send_byte(MARK_LEAD);
      send_byte(MARK_EOI);
      send_byte(MARK_SOI);

      // The receiver holds off while a long frame is offered, so the block must stall its input.
      hold_request = 300;
      send_frame(60, 1'b1);
      drain();

      csr_write(UNMAPPED_ADDR, 32'd5);
      check_limit_reg();
      program_limit(32'd4);
      send_frame(3, 1'b0);
      send_byte(MARK_LEAD);
      send_byte(MARK_SOI);
      send_byte(8'h11);
      send_byte(MARK_LEAD);
      send_byte(MARK_EOI);
      drain();
      program_limit(32'd1);
      send_frame(1, 1'b0);
      drain();

      limits[0] = 32'd4;
      limits[1] = 32'd67108864;
      limits[2] = 32'd6;
      limits[3] = $urandom_range(40, 4);
      limits[4] = CSR_DATA_BITS'(LIMIT_RESET);
      limits[5] = 32'd1000;
      limits[6] = $urandom_range(67108864, 4);
      limits[7] = 32'd12;
      for (phase = 0; phase < 8; phase++) begin
         drain();
         program_limit(limits[phase]);
         for (mode = 0; mode < 4; mode++) begin
            case (mode)
               0: begin
                  idle_pct = 0;
                  stall_pct = 0;
               end
               1: begin
                  idle_pct = 68;
                  stall_pct = 0;
               end
               2: begin
                  idle_pct = 0;
                  stall_pct = 68;
               end
               default: begin
                  idle_pct = 27;
                  stall_pct = 27;
               end
            endcase
            random_traffic(22);
         end
      end
      drain();

      $display("Sent %0d stream bytes under %0d size limits; checked %0d frame bytes.",
               bytes_sent, limit_settings, tracker.checked);
      $display("Frames closed by an end marker: %0d, frames dropped over the limit: %0d.",
               tracker.closed_frames, tracker.dropped_frames);
      if (tracker.failures == 0 && tracker.outstanding() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[files.f]
hdl/jfd_pkg.sv
hdl/jfd_front.sv
hdl/jfd_queue.sv
hdl/jfd_back.sv
hdl/jpeg_frame_deframer_core.sv
verif/tb_jpeg_frame_deframer_core.sv
